// ----- hdl/hqc_pkg.sv -----
`default_nettype none

package hqc_pkg;

    // Fixed field widths.
    localparam int COEF_W  = 48;
    localparam int DIM_W   = 12;
    localparam int COORD_W = 32;
    localparam int AREA_W  = 40;
    localparam int SUM_W   = 64;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;

    // Defaults for the top-level parameters.
    localparam int COORD_FRAC_BITS = 8;
    localparam int FIFO_DEPTH      = 4;

    // Six projected points per item.
    localparam int NUM_POINTS = 6;

    // Register indexes (byte address is eight times the index).
    localparam logic [1:0] REG_MODEL_HEIGHT = 2'd0;
    localparam logic [1:0] REG_MIN_AREA     = 2'd1;
    localparam logic [1:0] REG_MAX_AREA     = 2'd2;

    // Register reset values.
    localparam logic [DIM_W-1:0]  HEIGHT_RST   = 12'd200;
    localparam logic [AREA_W-1:0] MIN_AREA_RST = 40'd20000;
    localparam logic [AREA_W-1:0] MAX_AREA_RST = 40'd200000;

    // Saturation limits of a projected coordinate.
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    // Point order of one item: four corners, center, direction point.
    typedef enum logic [2:0] {
        K_C0     = 3'd0,
        K_C1     = 3'd1,
        K_C2     = 3'd2,
        K_C3     = 3'd3,
        K_CENTER = 3'd4,
        K_DIR    = 3'd5
    } t_kind;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [8:0] t_hmat;

    // One point ready for the divide: x and y numerators and the divisor.
    typedef struct packed {
        logic signed [SUM_W-1:0] nx;
        logic signed [SUM_W-1:0] ny;
        logic signed [SUM_W-1:0] den;
    } t_proj;

    // Divider result.
    typedef struct packed {
        logic signed [COORD_W-1:0] q;
        logic                      fault;
    } t_div_res;

endpackage

`default_nettype wire

// ----- hdl/hqc_front.sv -----
`default_nettype none

module hqc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  hqc_pkg::t_hmat                 i_h,
    input  logic [hqc_pkg::DIM_W-1:0]      i_width,
    input  logic [hqc_pkg::DIM_W-1:0]      i_height,
    input  logic                           i_fifo_afull,
    output logic                           o_fifo_push,
    output hqc_pkg::t_proj                 o_fifo_data
);

    logic                          r_busy;
    hqc_pkg::t_kind                r_kind;
    hqc_pkg::t_hmat                r_h;
    logic [hqc_pkg::DIM_W-1:0]     r_width;
    logic                          r_pv;
    logic signed [61:0]            r_p [6];
    hqc_pkg::t_coef                r_k [3];

    logic                          w_issue;
    logic                          w_accept;
    logic [12:0]                   w_mx;
    logic [12:0]                   w_my;
    logic signed [13:0]            w_smx;
    logic signed [13:0]            w_smy;

    // A point is issued only when the queue has room for it and the one in flight.
    assign w_issue  = r_busy && !i_fifo_afull;
    assign o_full   = r_busy && !(w_issue && (r_kind == hqc_pkg::K_DIR));
    assign w_accept = i_push && !o_full;

    // Model coordinates, doubled so that half the height stays exact.
    always_comb begin
        w_mx = '0;
        w_my = '0;
        unique case (r_kind)
            hqc_pkg::K_C0: begin
                w_mx = '0;
                w_my = '0;
            end
            hqc_pkg::K_C1: begin
                w_mx = {r_width, 1'b0};
                w_my = '0;
            end
            hqc_pkg::K_C2: begin
                w_mx = {r_width, 1'b0};
                w_my = {i_height, 1'b0};
            end
            hqc_pkg::K_C3: begin
                w_mx = '0;
                w_my = {i_height, 1'b0};
            end
            hqc_pkg::K_CENTER: begin
                w_mx = {1'b0, r_width[11:1], 1'b0};
                w_my = {1'b0, i_height};
            end
            hqc_pkg::K_DIR: begin
                w_mx = {r_width, 1'b0};
                w_my = {1'b0, i_height};
            end
            default: begin
                w_mx = '0;
                w_my = '0;
            end
        endcase
    end

    assign w_smx = {1'b0, w_mx};
    assign w_smy = {1'b0, w_my};

    // Item sequencing: a new item takes over as the last point of the old one issues.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= hqc_pkg::K_C0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_kind <= hqc_pkg::K_C0;
            end else if (w_issue) begin
                if (r_kind == hqc_pkg::K_DIR) begin
                    r_busy <= 1'b0;
                end else begin
                    r_kind <= hqc_pkg::t_kind'(r_kind + 3'd1);
                end
            end
        end
    end

    // Item capture and the product stage.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_h     <= i_h;
            r_width <= i_width;
        end
        if (w_issue) begin
            r_p[0] <= r_h[0] * w_smx;
            r_p[1] <= r_h[1] * w_smy;
            r_p[2] <= r_h[3] * w_smx;
            r_p[3] <= r_h[4] * w_smy;
            r_p[4] <= r_h[6] * w_smx;
            r_p[5] <= r_h[7] * w_smy;
            r_k[0] <= r_h[2];
            r_k[1] <= r_h[5];
            r_k[2] <= r_h[8];
        end
    end

    // Sum stage: the constant column is weighted by two in doubled coordinates.
    assign o_fifo_push     = r_pv;
    assign o_fifo_data.nx  = hqc_pkg::SUM_W'(r_p[0]) + hqc_pkg::SUM_W'(r_p[1])
                           + {{15{r_k[0][47]}}, r_k[0], 1'b0};
    assign o_fifo_data.ny  = hqc_pkg::SUM_W'(r_p[2]) + hqc_pkg::SUM_W'(r_p[3])
                           + {{15{r_k[1][47]}}, r_k[1], 1'b0};
    assign o_fifo_data.den = hqc_pkg::SUM_W'(r_p[4]) + hqc_pkg::SUM_W'(r_p[5])
                           + {{15{r_k[2][47]}}, r_k[2], 1'b0};

endmodule

`default_nettype wire

// ----- hdl/hqc_fifo.sv -----
`default_nettype none

module hqc_fifo #(
    parameter int DEPTH = hqc_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hqc_pkg::t_proj i_data,
    input  logic           i_pop,
    output hqc_pkg::t_proj o_data,
    output logic           o_empty,
    output logic           o_afull
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hqc_pkg::t_proj  r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_afull = (r_cnt >= CW'(DEPTH - 1));
    assign o_data  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hqc_div.sv -----
`default_nettype none

module hqc_div #(
    parameter int FRAC = hqc_pkg::COORD_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [63:0]       i_num,
    input  logic signed [63:0]       i_den,
    output logic                     o_done,
    output hqc_pkg::t_div_res        o_res
);

    localparam int NW = 64 + FRAC;

    typedef enum logic [4:0] {
        DS_IDLE = 5'b00001,
        DS_CHK  = 5'b00010,
        DS_RUN  = 5'b00100,
        DS_SAT  = 5'b01000,
        DS_DONE = 5'b10000
    } t_div_state;

    t_div_state          r_st;
    logic                r_neg;
    logic                r_nsign;
    logic                r_zero;
    logic                r_ovf;
    logic [63:0]         r_un;
    logic [63:0]         r_ud;
    logic [63:0]         r_rem;
    logic [31:0]         r_lo;
    logic [31:0]         r_q;
    logic [4:0]          r_cnt;
    hqc_pkg::t_div_res   r_res;

    logic [NW-1:0]       w_n;
    logic [63:0]         w_nhi;
    logic [64:0]         w_trial;
    logic [65:0]         w_diff;
    logic                w_ge;
    logic                w_big;
    logic                w_sneg;

    // Scaled dividend; its upper part decides whether the quotient fits 32 bits.
    assign w_n   = NW'(r_un) << FRAC;
    assign w_nhi = 64'(w_n[NW-1:32]);

    // One restoring step per cycle.
    assign w_trial = {r_rem, r_lo[31]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_ud};
    assign w_ge    = !w_diff[65];

    // A negative result may reach 2^31, a positive one only 2^31 - 1.
    assign w_big  = r_neg ? (r_q[31] && (r_q[30:0] != '0)) : r_q[31];
    assign w_sneg = r_zero ? r_nsign : r_neg;

    // Sequencer: every divide takes the same number of cycles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DS_IDLE;
        end else begin
            unique case (r_st)
                DS_IDLE: if (i_start) r_st <= DS_CHK;
                DS_CHK:  r_st <= DS_RUN;
                DS_RUN:  if (r_cnt == 5'd31) r_st <= DS_SAT;
                DS_SAT:  r_st <= DS_DONE;
                DS_DONE: r_st <= DS_IDLE;
                default: r_st <= DS_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if ((r_st == DS_IDLE) && i_start) begin
            r_neg   <= i_num[63] ^ i_den[63];
            r_nsign <= i_num[63];
            r_un    <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_ud    <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_zero  <= (i_den == '0);
        end
        if (r_st == DS_CHK) begin
            r_ovf <= (w_nhi >= r_ud);
            r_rem <= w_nhi;
            r_lo  <= w_n[31:0];
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (r_st == DS_RUN) begin
            r_rem <= w_ge ? w_diff[63:0] : w_trial[63:0];
            r_lo  <= {r_lo[30:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (r_st == DS_SAT) begin
            if (r_ovf || w_big) begin
                r_res.q     <= w_sneg ? hqc_pkg::COORD_MIN : hqc_pkg::COORD_MAX;
                r_res.fault <= 1'b1;
            end else begin
                r_res.q     <= r_neg ? (32'd0 - r_q) : r_q;
                r_res.fault <= 1'b0;
            end
        end
    end

    assign o_done = (r_st == DS_DONE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ----- hdl/hqc_back.sv -----
`default_nettype none

module hqc_back #(
    parameter int FRAC = hqc_pkg::COORD_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fifo_empty,
    input  hqc_pkg::t_proj                  i_fifo_data,
    output logic                            o_fifo_pop,
    input  logic [hqc_pkg::AREA_W-1:0]      i_min_area,
    input  logic [hqc_pkg::AREA_W-1:0]      i_max_area,
    input  logic                            i_pop,
    output logic                            o_empty,
    output hqc_pkg::t_kind                  o_kind,
    output logic signed [31:0]              o_x,
    output logic signed [31:0]              o_y,
    output logic [hqc_pkg::AREA_W-1:0]      o_area,
    output logic                            o_convex,
    output logic                            o_ok,
    output logic                            o_last
);

    localparam int NP    = hqc_pkg::NUM_POINTS;
    localparam int CNT_W = $clog2(NP + 1);
    localparam int ACC_W = 70;
    localparam int SH    = 2 * FRAC + 1;
    localparam logic [ACC_W-1:0] REM_MASK = (ACC_W'(1) << SH) - ACC_W'(1);

    typedef enum logic [5:0] {
        BS_FETCH = 6'b000001,
        BS_DIV   = 6'b000010,
        BS_GEOM  = 6'b000100,
        BS_ABS   = 6'b001000,
        BS_CMP   = 6'b010000,
        BS_OUT   = 6'b100000
    } t_back_state;

    t_back_state               r_st;
    logic [2:0]                r_pt;
    logic [2:0]                r_gi;
    logic signed [31:0]        r_px [NP];
    logic signed [31:0]        r_py [NP];
    logic                      r_fault;
    logic signed [65:0]        r_m1;
    logic signed [65:0]        r_m2;
    logic signed [65:0]        r_m3;
    logic                      r_pos;
    logic                      r_negc;
    logic signed [ACC_W-1:0]   r_sum;
    logic [ACC_W-1:0]          r_abs;
    logic [hqc_pkg::AREA_W-1:0] r_area;
    logic                      r_convex;
    logic                      r_ok;
    logic signed [31:0]        r_ox [NP];
    logic signed [31:0]        r_oy [NP];
    logic [CNT_W-1:0]          r_ocnt;
    logic [hqc_pkg::AREA_W-1:0] r_oarea;
    logic                      r_oconvex;
    logic                      r_ook;

    logic                      w_start;
    logic                      w_done_x;
    logic                      w_done_y;
    logic                      w_done;
    hqc_pkg::t_div_res         w_res_x;
    hqc_pkg::t_div_res         w_res_y;
    logic signed [32:0]        w_ax;
    logic signed [32:0]        w_ay;
    logic signed [32:0]        w_bx;
    logic signed [32:0]        w_by;
    logic signed [32:0]        w_sx;
    logic signed [32:0]        w_dy;
    logic signed [65:0]        w_m1;
    logic signed [65:0]        w_m2;
    logic signed [65:0]        w_m3;
    logic [66:0]               w_cr;
    logic [ACC_W-1:0]          w_area_full;
    logic                      w_rem;
    logic                      w_above;
    logic                      w_below;

    // Fetch one point from the queue and start both divides.
    assign w_start    = (r_st == BS_FETCH) && !i_fifo_empty;
    assign o_fifo_pop = w_start;
    assign w_done     = w_done_x && w_done_y;

    hqc_div #(.FRAC(FRAC)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (i_fifo_data.nx),
        .i_den   (i_fifo_data.den),
        .o_done  (w_done_x),
        .o_res   (w_res_x)
    );

    hqc_div #(.FRAC(FRAC)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (i_fifo_data.ny),
        .i_den   (i_fifo_data.den),
        .o_done  (w_done_y),
        .o_res   (w_res_y)
    );

    // Corner ring: slot 0 is the current corner, 1 and 2 the next two, 3 the previous.
    assign w_ax = 33'(r_px[2]) - 33'(r_px[1]);
    assign w_ay = 33'(r_py[2]) - 33'(r_py[1]);
    assign w_bx = 33'(r_px[1]) - 33'(r_px[0]);
    assign w_by = 33'(r_py[1]) - 33'(r_py[0]);
    assign w_sx = 33'(r_px[3]) + 33'(r_px[0]);
    assign w_dy = 33'(r_py[3]) - 33'(r_py[0]);
    assign w_m1 = w_ax * w_by;
    assign w_m2 = w_bx * w_ay;
    assign w_m3 = w_sx * w_dy;
    assign w_cr = {r_m1[65], r_m1} - {r_m2[65], r_m2};

    // Area limits are checked against the exact halved area.
    assign w_area_full = r_abs >> SH;
    assign w_rem       = (r_abs & REM_MASK) != '0;
    assign w_above     = (w_area_full > ACC_W'(i_min_area))
                      || ((w_area_full == ACC_W'(i_min_area)) && w_rem);
    assign w_below     = w_area_full < ACC_W'(i_max_area);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_FETCH;
            r_pt <= '0;
            r_gi <= '0;
        end else begin
            unique case (r_st)
                BS_FETCH: if (!i_fifo_empty) r_st <= BS_DIV;
                BS_DIV: begin
                    if (w_done) begin
                        if (r_pt == 3'(NP - 1)) begin
                            r_pt <= '0;
                            r_gi <= '0;
                            r_st <= BS_GEOM;
                        end else begin
                            r_pt <= r_pt + 3'd1;
                            r_st <= BS_FETCH;
                        end
                    end
                end
                BS_GEOM: begin
                    r_gi <= r_gi + 3'd1;
                    if (r_gi == 3'd4) r_st <= BS_ABS;
                end
                BS_ABS:  r_st <= BS_CMP;
                BS_CMP:  r_st <= BS_OUT;
                BS_OUT:  if (r_ocnt == '0) r_st <= BS_FETCH;
                default: r_st <= BS_FETCH;
            endcase
        end
    end

    // Point collection, geometry and the pass decision.
    always_ff @(posedge i_clk) begin
        if ((r_st == BS_DIV) && w_done) begin
            for (int k = 0; k < NP - 1; k++) begin
                r_px[k] <= r_px[k + 1];
                r_py[k] <= r_py[k + 1];
            end
            r_px[NP - 1] <= w_res_x.q;
            r_py[NP - 1] <= w_res_y.q;
            r_fault <= ((r_pt == '0) ? 1'b0 : r_fault) | w_res_x.fault | w_res_y.fault;
            r_pos   <= 1'b1;
            r_negc  <= 1'b1;
            r_sum   <= '0;
        end
        if (r_st == BS_GEOM) begin
            if (r_gi != 3'd4) begin
                r_m1 <= w_m1;
                r_m2 <= w_m2;
                r_m3 <= w_m3;
                for (int k = 0; k < 4; k++) begin
                    r_px[k] <= r_px[(k + 1) % 4];
                    r_py[k] <= r_py[(k + 1) % 4];
                end
            end
            if (r_gi != 3'd0) begin
                if (w_cr[66]) begin
                    r_pos <= 1'b0;
                end else begin
                    r_negc <= 1'b0;
                end
                r_sum <= r_sum + ACC_W'(r_m3);
            end
        end
        if (r_st == BS_ABS) begin
            r_abs <= r_sum[ACC_W-1] ? (ACC_W'(0) - r_sum) : r_sum;
        end
        if (r_st == BS_CMP) begin
            r_area   <= (w_area_full[ACC_W-1:hqc_pkg::AREA_W] != '0) ? '1
                                                                    : w_area_full[39:0];
            r_convex <= r_pos || r_negc;
            r_ok     <= w_above && w_below && (r_pos || r_negc) && !r_fault;
        end
    end

    // Result buffer: holds one item's six results while the next is computed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if ((r_st == BS_OUT) && (r_ocnt == '0)) begin
            r_ocnt <= CNT_W'(NP);
        end else if (i_pop && (r_ocnt != '0)) begin
            r_ocnt <= r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == BS_OUT) && (r_ocnt == '0)) begin
            for (int k = 0; k < NP; k++) begin
                r_ox[k] <= r_px[k];
                r_oy[k] <= r_py[k];
            end
            r_oarea   <= r_area;
            r_oconvex <= r_convex;
            r_ook     <= r_ok;
        end else if (i_pop && (r_ocnt != '0)) begin
            for (int k = 0; k < NP - 1; k++) begin
                r_ox[k] <= r_ox[k + 1];
                r_oy[k] <= r_oy[k + 1];
            end
        end
    end

    assign o_empty  = (r_ocnt == '0);
    assign o_kind   = hqc_pkg::t_kind'(CNT_W'(NP) - r_ocnt);
    assign o_x      = r_ox[0];
    assign o_y      = r_oy[0];
    assign o_area   = r_oarea;
    assign o_convex = r_oconvex;
    assign o_ok     = r_ook;
    assign o_last   = (r_ocnt == CNT_W'(1));

endmodule

`default_nettype wire

// ----- hdl/homography_quad_check.sv -----
`default_nettype none

// Projects the four corners, the center and the direction point of a model
// rectangle (model_width by model_height pixels) through a Q23.24 homography
// and checks the resulting quad: each input item yields six result items in
// the order corner 0..3, center, direction point, all carrying the same
// shoelace area, convexity flag and pass flag, with last_point set on the
// sixth. A zero divisor or a coordinate outside 32 bits saturates and fails
// the quad. Each point needs two 64-bit divides, done side by side by two
// restoring dividers: after fetch and setup they form one quotient bit per
// cycle, and then saturate. The cross products, the area compare and the
// hand-off to the result buffer follow. A queue ahead of the dividers and a
// six-entry result buffer let the next item enter and its divides run while
// the previous results wait. Registers sit on an APB port at byte addresses
// 0 (model_height), 8 (min_area) and 16 (max_area).
module homography_quad_check #(
    parameter int COORD_FRAC_BITS = hqc_pkg::COORD_FRAC_BITS,
    parameter int FIFO_DEPTH      = hqc_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item input
    input  logic                              push,
    output logic                              full,
    input  logic signed [47:0]                i_h00,
    input  logic signed [47:0]                i_h01,
    input  logic signed [47:0]                i_h02,
    input  logic signed [47:0]                i_h10,
    input  logic signed [47:0]                i_h11,
    input  logic signed [47:0]                i_h12,
    input  logic signed [47:0]                i_h20,
    input  logic signed [47:0]                i_h21,
    input  logic signed [47:0]                i_h22,
    input  logic [11:0]                       i_model_width,
    // Result output
    output logic                              empty,
    input  logic                              pop,
    output logic [2:0]                        o_point_kind,
    output logic signed [31:0]                o_point_x,
    output logic signed [31:0]                o_point_y,
    output logic [39:0]                       o_quad_area,
    output logic                              o_is_convex,
    output logic                              o_quad_ok,
    output logic                              o_last_point,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hqc_pkg::ADDR_W-1:0]        paddr,
    input  logic [hqc_pkg::DATA_W-1:0]        pwdata,
    output logic [hqc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [hqc_pkg::DIM_W-1:0]   r_model_height;
    logic [hqc_pkg::AREA_W-1:0]  r_min_area;
    logic [hqc_pkg::AREA_W-1:0]  r_max_area;

    logic                        w_cfg_wr;
    hqc_pkg::t_hmat              w_h;
    logic                        w_fifo_push;
    logic                        w_fifo_pop;
    logic                        w_fifo_empty;
    logic                        w_fifo_afull;
    hqc_pkg::t_proj              w_fifo_wdata;
    hqc_pkg::t_proj              w_fifo_rdata;
    hqc_pkg::t_kind              w_kind;

    // Register writes complete in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_height <= hqc_pkg::HEIGHT_RST;
            r_min_area     <= hqc_pkg::MIN_AREA_RST;
            r_max_area     <= hqc_pkg::MAX_AREA_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                hqc_pkg::REG_MODEL_HEIGHT: r_model_height <= pwdata[hqc_pkg::DIM_W-1:0];
                hqc_pkg::REG_MIN_AREA:     r_min_area     <= pwdata[hqc_pkg::AREA_W-1:0];
                hqc_pkg::REG_MAX_AREA:     r_max_area     <= pwdata[hqc_pkg::AREA_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:3])
            hqc_pkg::REG_MODEL_HEIGHT: prdata = hqc_pkg::DATA_W'(r_model_height);
            hqc_pkg::REG_MIN_AREA:     prdata = hqc_pkg::DATA_W'(r_min_area);
            hqc_pkg::REG_MAX_AREA:     prdata = hqc_pkg::DATA_W'(r_max_area);
            default:                   prdata = '0;
        endcase
    end

    // Homography in row-major order.
    assign w_h[0] = i_h00;
    assign w_h[1] = i_h01;
    assign w_h[2] = i_h02;
    assign w_h[3] = i_h10;
    assign w_h[4] = i_h11;
    assign w_h[5] = i_h12;
    assign w_h[6] = i_h20;
    assign w_h[7] = i_h21;
    assign w_h[8] = i_h22;

    hqc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_h          (w_h),
        .i_width      (i_model_width),
        .i_height     (r_model_height),
        .i_fifo_afull (w_fifo_afull),
        .o_fifo_push  (w_fifo_push),
        .o_fifo_data  (w_fifo_wdata)
    );

    hqc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fifo_push),
        .i_data  (w_fifo_wdata),
        .i_pop   (w_fifo_pop),
        .o_data  (w_fifo_rdata),
        .o_empty (w_fifo_empty),
        .o_afull (w_fifo_afull)
    );

    hqc_back #(.FRAC(COORD_FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (w_fifo_empty),
        .i_fifo_data  (w_fifo_rdata),
        .o_fifo_pop   (w_fifo_pop),
        .i_min_area   (r_min_area),
        .i_max_area   (r_max_area),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (w_kind),
        .o_x          (o_point_x),
        .o_y          (o_point_y),
        .o_area       (o_quad_area),
        .o_convex     (o_is_convex),
        .o_ok         (o_quad_ok),
        .o_last       (o_last_point)
    );

    assign o_point_kind = w_kind;

`ifndef SYNTHESIS
    // Once the sixth result of an item is taken, the next one shown starts a new item.
    a_item_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_point) |=> (empty || (o_point_kind == hqc_pkg::K_C0)))
        else $error("result after the last point does not start at corner 0");

    // A passing quad must be convex.
    a_ok_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_quad_ok) |-> o_is_convex)
        else $error("quad passes without being convex");

    // The last point flag marks the direction point only.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_point) |-> (o_point_kind == hqc_pkg::K_DIR))
        else $error("last point flag on a result other than the direction point");
`endif

endmodule

`default_nettype wire
